@@ src/wis_pkg.sv @@
// Shared types and constants for the weighted index sampler.
// No dependencies; imported by every module in src.
package wis_pkg;

	localparam int MAX_ENTRIES = 256;
	localparam int WEIGHT_BITS = 16;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = IDX_W + 1;
	localparam int SUM_W       = WEIGHT_BITS + IDX_W;
	localparam int WORD_W      = 32;
	localparam int STEP_W      = $clog2(WORD_W);

	typedef enum logic [1:0] {
		MODE_CLEAR  = 2'd0,
		MODE_APPEND = 2'd1,
		MODE_SAMPLE = 2'd2,
		MODE_QUERY  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_ZERO   = 2'd1,
		ST_FULL   = 2'd2,
		ST_BADPOS = 2'd3
	} status_t;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_DIV  = 7'b0000010,
		S_BRD  = 7'b0000100,
		S_BCMP = 7'b0001000,
		S_QA   = 7'b0010000,
		S_QB   = 7'b0100000,
		S_QC   = 7'b1000000
	} state_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		logic [SUM_W-1:0] data;
	} wis_wr_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
	} wis_rd_t;

endpackage

@@ src/wis_table.sv @@
// Running-sum table: one write port, one read port with registered read data.
// Depends on wis_pkg.
module wis_table (
	input  logic                         clk,
	input  wis_pkg::wis_wr_t             wr,
	input  wis_pkg::wis_rd_t             rd,
	output logic [wis_pkg::SUM_W-1:0]    rd_data
);
	import wis_pkg::*;

	logic [SUM_W-1:0] mem [MAX_ENTRIES];
	logic [SUM_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			rd_data_q <= mem[rd.addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ src/wis_mod.sv @@
// Bit-serial restoring modulo: one dividend bit per cycle, over all WORD_W dividend bits.
// Depends on wis_pkg. Divisor must stay stable while active.
module wis_mod (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [wis_pkg::WORD_W-1:0]    dividend,
	input  logic [wis_pkg::SUM_W-1:0]     divisor,
	output logic                          done,
	output logic [wis_pkg::SUM_W-1:0]     rem
);
	import wis_pkg::*;

	logic              active_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [WORD_W-1:0] word_q;
	logic [SUM_W-1:0]  rem_q;
	logic [SUM_W:0]    trial;
	logic [SUM_W:0]    diff;
	logic [SUM_W-1:0]  rem_next;

	// shift in next bit, subtract if it fits
	always_comb begin
		trial    = {rem_q, word_q[WORD_W-1]};
		diff     = trial - {1'b0, divisor};
		rem_next = (trial >= {1'b0, divisor}) ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			step_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				active_q <= 1'b1;
				step_q   <= '0;
			end else if (active_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(WORD_W - 1)) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			word_q <= dividend;
			rem_q  <= '0;
		end else if (active_q) begin
			word_q <= {word_q[WORD_W-2:0], 1'b0};
			rem_q  <= rem_next;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

@@ src/weighted_index_sampler_core.sv @@
// Top level of the weighted index sampler: command sequencer, bisection and query.
// Depends on wis_pkg, wis_table and wis_mod.
//
// One result word per accepted command, shown for one cycle with done high; the
// receiver cannot stall it. Clear, append, a sample with zero total and a query at
// a bad position are answered from S_IDLE. A query runs S_QA, S_QB and S_QC (two
// reads of the table's single read port plus a subtract). A sample first runs the
// bit-serial modulo by the total, then bisection steps of a table read (S_BRD) and a
// compare (S_BCMP), up to 8 steps at 256 entries. busy is high while a command is
// in progress; start is taken only while busy is low.
module weighted_index_sampler_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [1:0]                        mode,
	input  logic [wis_pkg::WEIGHT_BITS-1:0]   weight_in,
	input  logic [wis_pkg::WORD_W-1:0]        random_word,
	input  logic [wis_pkg::IDX_W-1:0]         position,
	output logic                              done,
	output logic [wis_pkg::IDX_W-1:0]         chosen_index,
	output logic [wis_pkg::WEIGHT_BITS-1:0]   weight_out,
	output logic [wis_pkg::CNT_W-1:0]         entry_total,
	output logic [1:0]                        status
);
	import wis_pkg::*;

	state_t            state_q;
	logic [CNT_W-1:0]  count_q;
	logic [SUM_W-1:0]  sum_q;
	logic              done_q;
	logic [IDX_W-1:0]  chosen_q;
	logic [WEIGHT_BITS-1:0] wout_q;
	logic [CNT_W-1:0]  total_q;
	status_t           status_q;

	logic [CNT_W-1:0]  lo_q;
	logic [CNT_W-1:0]  hi_q;
	logic [IDX_W-1:0]  pos_q;
	logic [SUM_W-1:0]  base_q;

	logic              accept;
	mode_t             cmd;
	logic              full;
	logic [CNT_W:0]    lo_inc;
	logic [CNT_W:0]    mid_sum;
	logic [CNT_W-1:0]  mid;
	logic              bis_go;
	logic [CNT_W-1:0]  pos_inc;
	logic              upper_in_tab;
	logic [SUM_W-1:0]  upper;
	logic [SUM_W-1:0]  wdiff;

	wis_wr_t           wr;
	wis_rd_t           rd;
	logic [SUM_W-1:0]  rd_data;
	logic              div_start;
	logic              div_done;
	logic [SUM_W-1:0]  div_rem;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign cmd    = mode_t'(mode);
	assign full   = (count_q == CNT_W'(MAX_ENTRIES));

	always_comb begin
		lo_inc       = {1'b0, lo_q} + 1'b1;
		bis_go       = (lo_inc < {1'b0, hi_q});
		mid_sum      = {1'b0, lo_q} + {1'b0, hi_q};
		mid          = mid_sum[CNT_W:1];
		pos_inc      = {1'b0, pos_q} + 1'b1;
		upper_in_tab = (pos_inc < count_q);
		upper        = upper_in_tab ? rd_data : sum_q;
		wdiff        = upper - base_q;
	end

	assign div_start = accept && (cmd == MODE_SAMPLE) && (sum_q != '0);

	always_comb begin
		wr.en   = accept && (cmd == MODE_APPEND) && !full;
		wr.addr = count_q[IDX_W-1:0];
		wr.data = sum_q;
	end

	always_comb begin
		rd.en   = 1'b0;
		rd.addr = pos_q;
		unique case (state_q)
			S_BRD: begin
				rd.en   = bis_go;
				rd.addr = mid[IDX_W-1:0];
			end
			S_QA: begin
				rd.en   = 1'b1;
				rd.addr = pos_q;
			end
			S_QB: begin
				rd.en   = upper_in_tab;
				rd.addr = pos_inc[IDX_W-1:0];
			end
			default: begin
				rd.en   = 1'b0;
				rd.addr = pos_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			sum_q    <= '0;
			done_q   <= 1'b0;
			chosen_q <= '0;
			wout_q   <= '0;
			total_q  <= '0;
			status_q <= ST_OK;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						chosen_q <= '0;
						wout_q   <= '0;
						status_q <= ST_OK;
						unique case (cmd)
							MODE_CLEAR: begin
								count_q <= '0;
								sum_q   <= '0;
								total_q <= '0;
								done_q  <= 1'b1;
							end
							MODE_APPEND: begin
								done_q <= 1'b1;
								if (full) begin
									status_q <= ST_FULL;
									total_q  <= count_q;
								end else begin
									sum_q   <= sum_q + SUM_W'(weight_in);
									count_q <= count_q + 1'b1;
									total_q <= count_q + 1'b1;
								end
							end
							MODE_SAMPLE: begin
								total_q <= count_q;
								if (sum_q == '0) begin
									status_q <= ST_ZERO;
									done_q   <= 1'b1;
								end else begin
									state_q <= S_DIV;
								end
							end
							MODE_QUERY: begin
								total_q <= count_q;
								if ({1'b0, position} >= count_q) begin
									status_q <= ST_BADPOS;
									done_q   <= 1'b1;
								end else begin
									state_q <= S_QA;
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_BRD;
					end
				end
				S_BRD: begin
					if (bis_go) begin
						state_q <= S_BCMP;
					end else begin
						chosen_q <= lo_q[IDX_W-1:0];
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				S_BCMP: begin
					state_q <= S_BRD;
				end
				S_QA: begin
					state_q <= S_QB;
				end
				S_QB: begin
					state_q <= S_QC;
				end
				S_QC: begin
					wout_q  <= wdiff[WEIGHT_BITS-1:0];
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// bisection bounds and query operands
	always_ff @(posedge clk) begin
		if (accept) begin
			pos_q <= position;
		end
		if (state_q == S_DIV && div_done) begin
			lo_q <= '0;
			hi_q <= count_q;
		end
		if (state_q == S_BCMP) begin
			if (rd_data <= div_rem) begin
				lo_q <= mid;
			end else begin
				hi_q <= mid;
			end
		end
		if (state_q == S_QB) begin
			base_q <= rd_data;
		end
	end

	wis_table u_table (
		.clk     (clk),
		.wr      (wr),
		.rd      (rd),
		.rd_data (rd_data)
	);

	wis_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (random_word),
		.divisor  (sum_q),
		.done     (div_done),
		.rem      (div_rem)
	);

	assign done         = done_q;
	assign chosen_index = chosen_q;
	assign weight_out   = wout_q;
	assign entry_total  = total_q;
	assign status       = status_q;

endmodule

@@ tb/wis_checker.sv @@
`timescale 1ns / 100ps
// Result checker for weighted_index_sampler_core: keeps its own running-sum table,
// predicts one result word per accepted command and compares them in order.
// Depends on wis_pkg only; instantiated by tb beside the core.
module wis_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic                            busy,
	input  logic [1:0]                      mode,
	input  logic [wis_pkg::WEIGHT_BITS-1:0] weight_in,
	input  logic [wis_pkg::WORD_W-1:0]      random_word,
	input  logic [wis_pkg::IDX_W-1:0]       position,
	input  logic                            done,
	input  logic [wis_pkg::IDX_W-1:0]       chosen_index,
	input  logic [wis_pkg::WEIGHT_BITS-1:0] weight_out,
	input  logic [wis_pkg::CNT_W-1:0]       entry_total,
	input  logic [1:0]                      status,
	output int                              err_count,
	output int                              words_pending
);
	import wis_pkg::*;

	typedef struct packed {
		logic [IDX_W-1:0]       index;
		logic [WEIGHT_BITS-1:0] weight;
		logic [CNT_W-1:0]       total;
		status_t                st;
	} sampler_word_t;

	logic [SUM_W-1:0] run_sum_tbl [MAX_ENTRIES];
	logic [CNT_W-1:0] n_loaded = '0;
	logic [SUM_W-1:0] total_weight = '0;
	sampler_word_t    expected_q [$];
	int               fails = 0;

	// running sum ahead of entry i; the entry count maps to the total
	function automatic logic [SUM_W-1:0] sum_before(input int i);
		return (i >= n_loaded) ? total_weight : run_sum_tbl[i[IDX_W-1:0]];
	endfunction

	function automatic sampler_word_t predict_word(input mode_t m,
			input logic [WEIGHT_BITS-1:0] w, input logic [WORD_W-1:0] rw,
			input logic [IDX_W-1:0] p);
		sampler_word_t r;
		logic [WORD_W-1:0] target;
		logic [SUM_W-1:0] diff;
		int lo, hi, mid;
		r.index = '0;
		r.weight = '0;
		r.st = ST_OK;
		case (m)
			MODE_CLEAR: begin
				n_loaded = '0;
				total_weight = '0;
			end
			MODE_APPEND: begin
				if (n_loaded == MAX_ENTRIES) begin
					r.st = ST_FULL;
				end else begin
					run_sum_tbl[n_loaded[IDX_W-1:0]] = total_weight;
					total_weight = total_weight + SUM_W'(w);
					n_loaded = n_loaded + 1'b1;
				end
			end
			MODE_SAMPLE: begin
				if (total_weight == '0) begin
					r.st = ST_ZERO;
				end else begin
					target = rw % WORD_W'(total_weight);
					lo = 0;
					hi = int'(n_loaded);
					while (lo + 1 < hi) begin
						mid = (lo + hi) / 2;
						if (WORD_W'(sum_before(mid)) <= target)
							lo = mid;
						else
							hi = mid;
					end
					r.index = lo[IDX_W-1:0];
				end
			end
			default: begin
				if (CNT_W'(p) >= n_loaded) begin
					r.st = ST_BADPOS;
				end else begin
					diff = sum_before(int'(p) + 1) - sum_before(int'(p));
					r.weight = diff[WEIGHT_BITS-1:0];
				end
			end
		endcase
		r.total = n_loaded;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			fails++;
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		sampler_word_t want;
		if (!arst_n) begin
			n_loaded = '0;
			total_weight = '0;
			expected_q.delete();
			words_pending <= 0;
			err_count <= fails;
		end else begin
			// push first: a word accepted now is never the one shown now
			if (start && !busy)
				expected_q.push_back(predict_word(mode_t'(mode), weight_in, random_word,
						position));
			if (done) begin
				if (expected_q.size() == 0) begin
					fails++;
					$display("%0t ns: unexpected result word, expected none, got idx %0d wt %0d cnt %0d st %0d",
							$time, chosen_index, weight_out, entry_total, status);
				end else begin
					want = expected_q.pop_front();
					check_field("chosen_index", 32'(want.index), 32'(chosen_index));
					check_field("weight_out", 32'(want.weight), 32'(weight_out));
					check_field("entry_total", 32'(want.total), 32'(entry_total));
					check_field("status", 32'(want.st), 32'(status));
				end
			end
			words_pending <= expected_q.size();
			err_count <= fails;
		end
	end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// Testbench top for weighted_index_sampler_core: clock, reset, command stimulus, verdict.
// Depends on wis_pkg, the core in src and wis_checker, which does all the checking.
module tb;
	import wis_pkg::*;

	localparam int RAND_WORDS   = 550;
	localparam int LIMIT_CYCLES = 400000;
	localparam int TAIL_CYCLES  = 60;
	localparam int BIG_SET      = 5;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   start;
	logic                   busy;
	mode_t                  mode;
	logic [WEIGHT_BITS-1:0] weight_in;
	logic [WORD_W-1:0]      random_word;
	logic [IDX_W-1:0]       position;
	logic                   done;
	logic [IDX_W-1:0]       chosen_index;
	logic [WEIGHT_BITS-1:0] weight_out;
	logic [CNT_W-1:0]       entry_total;
	logic [1:0]             status;
	int                     fail_total;
	int                     words_pending;

	int idle_pct = 0;
	int words_sent = 0;
	int loaded_n = 0;
	int loaded_sum = 0;
	int cycle_no = 0;
	int idle_table [4] = '{0, 85, 7, 0};

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	weighted_index_sampler_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.mode         (mode),
		.weight_in    (weight_in),
		.random_word  (random_word),
		.position     (position),
		.done         (done),
		.chosen_index (chosen_index),
		.weight_out   (weight_out),
		.entry_total  (entry_total),
		.status       (status)
	);

	wis_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.mode          (mode),
		.weight_in     (weight_in),
		.random_word   (random_word),
		.position      (position),
		.done          (done),
		.chosen_index  (chosen_index),
		.weight_out    (weight_out),
		.entry_total   (entry_total),
		.status        (status),
		.err_count     (fail_total),
		.words_pending (words_pending)
	);

	always @(posedge clk) begin
		cycle_no <= cycle_no + 1;
		if (cycle_no >= LIMIT_CYCLES) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// drive one command word and hold it until the core takes it
	task automatic issue_word(input mode_t m, input logic [WEIGHT_BITS-1:0] w,
			input logic [WORD_W-1:0] rw, input logic [IDX_W-1:0] p);
		start <= 1'b1;
		mode <= m;
		weight_in <= w;
		random_word <= rw;
		position <= p;
		do @(posedge clk); while (busy);
		words_sent++;
		if (m == MODE_CLEAR) begin
			loaded_n = 0;
			loaded_sum = 0;
		end else if (m == MODE_APPEND && loaded_n < MAX_ENTRIES) begin
			loaded_n++;
			loaded_sum += int'(w);
		end
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			mode <= mode_t'($urandom_range(3));
			weight_in <= WEIGHT_BITS'($urandom);
			random_word <= $urandom;
			position <= IDX_W'($urandom);
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
	endtask

	task automatic drain_results();
		start <= 1'b0;
		do @(posedge clk); while (words_pending != 0);
	endtask

	initial begin
		int set_no, n_app, n_ops, sel, pick, last_word;
		logic [WEIGHT_BITS-1:0] w;
		logic [WORD_W-1:0] rw;
		logic [IDX_W-1:0] p;

		arst_n <= 1'b0;
		start <= 1'b0;
		mode <= MODE_CLEAR;
		weight_in <= '0;
		random_word <= '0;
		position <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table: zero total and bad position
		issue_word(MODE_SAMPLE, WEIGHT_BITS'($urandom), 32'h0000_1234, IDX_W'($urandom));
		issue_word(MODE_QUERY, WEIGHT_BITS'($urandom), $urandom, 8'd0);
		// a lone zero weight still gives a zero total
		issue_word(MODE_APPEND, 16'd0, $urandom, IDX_W'($urandom));
		issue_word(MODE_SAMPLE, WEIGHT_BITS'($urandom), 32'hFFFF_FFFF, IDX_W'($urandom));
		issue_word(MODE_QUERY, WEIGHT_BITS'($urandom), $urandom, 8'd0);
		issue_word(MODE_APPEND, 16'hFFFF, $urandom, IDX_W'($urandom));
		issue_word(MODE_APPEND, 16'd0, $urandom, IDX_W'($urandom));
		issue_word(MODE_APPEND, 16'd1, $urandom, IDX_W'($urandom));
		issue_word(MODE_APPEND, 16'h8000, $urandom, IDX_W'($urandom));
		// values landing on interval edges; zero-weight entries must never come out
		issue_word(MODE_SAMPLE, WEIGHT_BITS'($urandom), 32'd0, IDX_W'($urandom));
		issue_word(MODE_SAMPLE, WEIGHT_BITS'($urandom), 32'hFFFF_FFFF, IDX_W'($urandom));
		issue_word(MODE_SAMPLE, WEIGHT_BITS'($urandom), 32'd65535, IDX_W'($urandom));
		issue_word(MODE_SAMPLE, WEIGHT_BITS'($urandom), 32'd65536, IDX_W'($urandom));
		issue_word(MODE_SAMPLE, WEIGHT_BITS'($urandom), 32'd98303, IDX_W'($urandom));
		issue_word(MODE_QUERY, WEIGHT_BITS'($urandom), $urandom, 8'd1);
		issue_word(MODE_QUERY, WEIGHT_BITS'($urandom), $urandom, 8'd4);
		issue_word(MODE_QUERY, WEIGHT_BITS'($urandom), $urandom, 8'd5);
		issue_word(MODE_QUERY, WEIGHT_BITS'($urandom), $urandom, 8'd255);
		issue_word(MODE_CLEAR, WEIGHT_BITS'($urandom), $urandom, IDX_W'($urandom));
		issue_word(MODE_SAMPLE, WEIGHT_BITS'($urandom), 32'd7, IDX_W'($urandom));
		issue_word(MODE_QUERY, WEIGHT_BITS'($urandom), $urandom, 8'd0);
		issue_word(MODE_APPEND, 16'd1, $urandom, IDX_W'($urandom));
		issue_word(MODE_SAMPLE, WEIGHT_BITS'($urandom), 32'hFFFF_FFFF, IDX_W'($urandom));

		// random sets: clear (mostly), a run of appends, then samples, queries and noise
		last_word = words_sent + RAND_WORDS;
		set_no = 0;
		while (words_sent < last_word) begin
			idle_pct = idle_table[(set_no / 6) % 4];
			if (set_no == 3)
				drain_results();
			if (set_no == 0 || set_no == BIG_SET || $urandom_range(5) != 0)
				issue_word(MODE_CLEAR, WEIGHT_BITS'($urandom), $urandom,
						IDX_W'($urandom));
			// one set fills the table past full, mostly with the largest weight
			n_app = (set_no == BIG_SET) ? MAX_ENTRIES + 2 : $urandom_range(1, 12);
			for (int i = 0; i < n_app; i++) begin
				sel = $urandom_range(9);
				if (set_no == BIG_SET && sel < 7)
					w = '1;
				else if (sel == 0)
					w = '0;
				else if (sel == 1)
					w = '1;
				else if (sel < 4)
					w = WEIGHT_BITS'($urandom_range(1, 15));
				else
					w = WEIGHT_BITS'($urandom);
				issue_word(MODE_APPEND, w, $urandom, IDX_W'($urandom));
			end
			n_ops = (set_no == BIG_SET) ? 40 : $urandom_range(2, 10);
			for (int i = 0; i < n_ops; i++) begin
				sel = $urandom_range(99);
				if (sel < 50) begin
					pick = $urandom_range(9);
					if (pick == 0)
						rw = '0;
					else if (pick == 1)
						rw = '1;
					else if (pick == 2 && loaded_sum != 0)
						rw = loaded_sum - 1;
					else
						rw = $urandom;
					issue_word(MODE_SAMPLE, WEIGHT_BITS'($urandom), rw, IDX_W'($urandom));
				end else if (sel < 85) begin
					if (loaded_n != 0 && $urandom_range(3) != 0)
						p = IDX_W'($urandom_range(loaded_n - 1));
					else
						p = IDX_W'($urandom);
					issue_word(MODE_QUERY, WEIGHT_BITS'($urandom), $urandom, p);
				end else begin
					issue_word(mode_t'($urandom_range(3)), WEIGHT_BITS'($urandom),
							$urandom, IDX_W'($urandom));
				end
			end
			set_no++;
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_total == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
